/* sv/tmlr_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the tile map line renderer
// no dependencies

package tmlr_pkg;

  localparam int VIDEO_BYTES = 8192;
  localparam int ADDR_W      = $clog2(VIDEO_BYTES);

  // input kinds carried on s_tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // register indexes on the config port
  localparam logic [1:0] REG_SCROLL_X    = 2'd0;
  localparam logic [1:0] REG_SCROLL_Y    = 2'd1;
  localparam logic [1:0] REG_MAP_SELECT  = 2'd2;
  localparam logic [1:0] REG_DATA_SELECT = 2'd3;

  // map base 0x1800 / 0x1C00: top two address bits set, bit 10 picks the map
  localparam logic [1:0] MAP_HI_BITS = 2'b11;

  localparam logic [8:0] VIEW_W = 9'd160;
  localparam logic [8:0] VIEW_H = 9'd144;

  localparam logic [1:0] COLOUR_GRID    = 2'd1;
  localparam logic [1:0] COLOUR_OUTLINE = 2'd3;

  // one fetched tile line, handed to the pixel serializer
  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [4:0] row;
    logic [4:0] col;
    logic [2:0] line;
  } line_t;

  function automatic logic [7:0] shade_of(input logic [1:0] colour);
    logic [7:0] s;
    unique case (colour)
      2'd0: s = 8'd255;
      2'd1: s = 8'd128;
      2'd2: s = 8'd64;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

/* sv/tmlr_vram.sv */
`timescale 1ns / 1ps
// video memory: one write port, two read ports, registered read data
// uses tmlr_pkg

module tmlr_vram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tmlr_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic [tmlr_pkg::ADDR_W-1:0] raddr_a,
  output logic [7:0]                 rdata_a,
  input  logic [tmlr_pkg::ADDR_W-1:0] raddr_b,
  output logic [7:0]                 rdata_b
);
  import tmlr_pkg::*;

  logic [7:0] mem [VIDEO_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* sv/tmlr_serializer.sv */
`timescale 1ns / 1ps
// turns one fetched tile line into eight pixel words with grid and viewport outline
// uses tmlr_pkg

module tmlr_serializer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            scroll_x,
  input  logic [7:0]            scroll_y,
  input  logic                  in_valid,
  input  tmlr_pkg::line_t       in_line,
  output logic                  in_ready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // pixel_x, pixel_y, shade
  output logic                  m_tlast    // last_pixel
);
  import tmlr_pkg::*;

  logic       busy;
  logic [2:0] pix;
  line_t      cur;
  logic       adv;

  logic [7:0] x;
  logic [7:0] y;
  logic [2:0] bit_sel;
  logic [1:0] colour;
  logic [8:0] x_right;
  logic [8:0] y_bottom;
  logic       on_vert;
  logic       on_horz;

  assign adv      = busy && (!m_tvalid || m_tready);
  assign in_ready = !busy || (adv && pix == 3'd7);

  always_comb begin
    x        = {cur.col, pix};
    y        = {cur.row, cur.line};
    bit_sel  = 3'd7 - pix;
    x_right  = {1'b0, scroll_x} + VIEW_W;
    y_bottom = {1'b0, scroll_y} + VIEW_H;
    colour   = {cur.hi[bit_sel], cur.lo[bit_sel]};
    if (pix == 3'd0 || cur.line == 3'd0) begin
      colour = COLOUR_GRID;
    end
    // edges compare against the wrapped position, spans compare without wrap
    on_vert = (x == scroll_x || x == x_right[7:0]) &&
              (y > scroll_y) && ({1'b0, y} < y_bottom);
    on_horz = (y == scroll_y || y == y_bottom[7:0]) &&
              (x > scroll_x) && ({1'b0, x} < x_right);
    if (on_vert || on_horz) begin
      colour = COLOUR_OUTLINE;
    end
  end

  // pix wraps back to zero on the eighth word, so it is zero whenever a line loads
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pix      <= 3'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {shade_of(colour), y, x};
        m_tlast  <= (pix == 3'd7);
        pix      <= pix + 3'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        cur  <= in_line;
        busy <= 1'b1;
      end else if (adv && pix == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* sv/tile_map_line_renderer_core.sv */
`timescale 1ns / 1ps
// top level: config registers, input handshake, map and tile fetch pipeline
// uses tmlr_pkg, tmlr_vram, tmlr_serializer

// A write word stores one byte into the 8 KiB video memory; writes can follow
// each other every cycle. A render word reads the tile index from the selected
// map in the cycle it is accepted, reads both bit planes of the tile line from
// the a stage, and parks the line, through the b stage, in the holding register;
// the serializer then emits eight pixel words, one a cycle while m_tready is
// high. The next word of either kind is taken once the fetch stages and holding
// register are free, so a render line can be fetched while the last line's
// pixels still go out, and render words are paced by the pixel output.
// Video memory has no reset: only bytes already written may be read.

module tile_map_line_renderer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mem_address, mem_data, map_row, map_col, tile_line
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // pixel_x, pixel_y, shade
  output logic        m_tlast    // last_pixel
);
  import tmlr_pkg::*;

  logic [7:0] scroll_x;
  logic [7:0] scroll_y;
  logic       map_select;
  logic       data_select;

  logic [ADDR_W-1:0] in_addr;
  logic [7:0]        in_data;
  logic [4:0]        in_row;
  logic [4:0]        in_col;
  logic [2:0]        in_line;
  logic              accept;

  logic a_valid;
  logic b_valid;
  logic h_valid;
  logic [4:0] a_row, b_row;
  logic [4:0] a_col, b_col;
  logic [2:0] a_line, b_line;
  line_t      hold;
  logic       h_ready;

  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [7:0]        rdata_a;
  logic [7:0]        rdata_b;
  logic              tile_b12;

  assign in_addr = s_tdata[12:0];
  assign in_data = s_tdata[20:13];
  assign in_row  = s_tdata[25:21];
  assign in_col  = s_tdata[30:26];
  assign in_line = s_tdata[33:31];

  assign s_tready = !a_valid && !b_valid && !h_valid;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x    <= 8'd0;
      scroll_y    <= 8'd0;
      map_select  <= 1'b0;
      data_select <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCROLL_X:    scroll_x    <= cfg_data;
        REG_SCROLL_Y:    scroll_y    <= cfg_data;
        REG_MAP_SELECT:  map_select  <= cfg_data[0];
        REG_DATA_SELECT: data_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // signed mode puts indices 0..127 at 0x1000 and 128..255 at 0x0800
  assign tile_b12 = !data_select && !rdata_a[7];

  always_comb begin
    if (a_valid) begin
      raddr_a = {tile_b12, rdata_a, a_line, 1'b0};
    end else begin
      raddr_a = {MAP_HI_BITS, map_select, in_row, in_col};
    end
    raddr_b = {tile_b12, rdata_a, a_line, 1'b1};
  end

  tmlr_vram u_vram (
    .clk     (clk),
    .we      (accept && s_tuser == OP_WRITE),
    .waddr   (in_addr),
    .wdata   (in_data),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      h_valid <= 1'b0;
    end else begin
      a_valid <= accept && s_tuser == OP_RENDER;
      b_valid <= a_valid;
      if (b_valid) begin
        h_valid <= 1'b1;
      end else if (h_ready) begin
        h_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_row  <= in_row;
      a_col  <= in_col;
      a_line <= in_line;
    end
    if (a_valid) begin
      b_row  <= a_row;
      b_col  <= a_col;
      b_line <= a_line;
    end
    if (b_valid) begin
      hold.lo   <= rdata_a;
      hold.hi   <= rdata_b;
      hold.row  <= b_row;
      hold.col  <= b_col;
      hold.line <= b_line;
    end
  end

  tmlr_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .scroll_x (scroll_x),
    .scroll_y (scroll_y),
    .in_valid (h_valid),
    .in_line  (hold),
    .in_ready (h_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
